@@ hdl/adc_scan_average_deadband_top_defines.svh @@
// assertion macros used by the scan-average top module
`ifndef ADC_SCAN_AVERAGE_DEADBAND_TOP_DEFINES_SVH
`define ADC_SCAN_AVERAGE_DEADBAND_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// condition must hold at every edge out of reset
`define ASAD_ASSERT(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("asad assertion failed");
// antecedent implies consequent in the next cycle
`define ASAD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("asad assertion failed");
`else
`define ASAD_ASSERT(lbl, clk, rstn, cond)
`define ASAD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ hdl/asad_pkg.sv @@
// ---------------------------------------------------------------------------
// asad_pkg
// Types and constants shared by the converter scan and average logic.
// ---------------------------------------------------------------------------
package asad_pkg;

  localparam int SAMPLE_W = 10;
  localparam int VALUE_W  = 16;
  localparam int COUNT_W  = 7;
  localparam int SHIFT_W  = 3;
  localparam int CHAN_W   = 2;
  localparam int DISC_W   = 2;
  localparam int CFG_IDX_W = 3;

  // scan channel codes
  localparam logic [CHAN_W-1:0] CH_CV_A  = 2'd0;
  localparam logic [CHAN_W-1:0] CH_GLIDE = 2'd1;
  localparam logic [CHAN_W-1:0] CH_CV_B  = 2'd2;
  localparam logic [CHAN_W-1:0] CH_BASE  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CV_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CV_SHIFT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CV_DEADBAND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GLIDE_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GLIDE_SHIFT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_COUNT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SHIFT  = 3'd6;

  // reset values of the configuration registers
  localparam logic [COUNT_W-1:0] RST_COUNT    = 7'd16;
  localparam logic [SHIFT_W-1:0] RST_SHIFT    = 3'd4;
  localparam logic [VALUE_W-1:0] RST_DEADBAND = 16'd2;

  typedef struct packed {
    logic [COUNT_W-1:0] cv_count;
    logic [SHIFT_W-1:0] cv_shift;
    logic [VALUE_W-1:0] cv_deadband;
    logic [COUNT_W-1:0] glide_count;
    logic [SHIFT_W-1:0] glide_shift;
    logic [COUNT_W-1:0] base_count;
    logic [SHIFT_W-1:0] base_shift;
  } asad_cfg_t;

  typedef struct packed {
    logic               update_valid;
    logic [CHAN_W-1:0]  update_channel;
    logic [VALUE_W-1:0] update_value;
    logic [CHAN_W-1:0]  scan_channel;
    logic [VALUE_W-1:0] query_value;
  } asad_res_t;

endpackage

@@ hdl/adc_scan_average_deadband_top.sv @@
// ---------------------------------------------------------------------------
// adc_scan_average_deadband_top
// Four-channel converter scan with oversampling average and cv deadband.
//
//   channel  direction  handshake          payload
//   in_      input      valid / stall      adc_sample, query_channel
//   out_     output     valid / stall      update_*, scan_channel, query_value
//   cfg_     input      valid / ready      index, data
//
// One sample per cycle while the result is not stalled; each sample passes the input
// register, then the accumulate / compare / store logic into the result register.
// Synchronous active-low reset clears scan state and stored values and loads config reset values.
// A stalled result holds both registers; the input side stalls only when
// both the input register and the result register are full.
// Config writes complete in the cycle they are presented.
// ---------------------------------------------------------------------------
`include "adc_scan_average_deadband_top_defines.svh"

module adc_scan_average_deadband_top
  import asad_pkg::*;
#(
  parameter int MAX_AVERAGE_COUNT = 64,
  parameter int SAMPLE_BITS       = 10,
  parameter int DISCARD_COUNT     = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SAMPLE_W-1:0]  in_adc_sample,
  input  logic [CHAN_W-1:0]    in_query_channel,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_update_valid,
  output logic [CHAN_W-1:0]    out_update_channel,
  output logic [VALUE_W-1:0]   out_update_value,
  output logic [CHAN_W-1:0]    out_scan_channel,
  output logic [VALUE_W-1:0]   out_query_value,
  // configuration write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VALUE_W-1:0]   cfg_data
);

  asad_cfg_t cfg_r, cfg_nxt;

  logic                s1_valid_r, s1_valid_nxt;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic [CHAN_W-1:0]   s1_query_r;

  logic                out_valid_r, out_valid_nxt;
  asad_res_t           out_res_r;
  asad_res_t           res;

  logic adv;
  logic step;
  logic in_xfer;

  // pipeline flow control
  assign adv      = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;
  assign in_xfer  = in_valid && !in_stall;

  assign cfg_ready = 1'b1;

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CV_COUNT:    cfg_nxt.cv_count    = cfg_data[COUNT_W-1:0];
        REG_CV_SHIFT:    cfg_nxt.cv_shift    = cfg_data[SHIFT_W-1:0];
        REG_CV_DEADBAND: cfg_nxt.cv_deadband = cfg_data;
        REG_GLIDE_COUNT: cfg_nxt.glide_count = cfg_data[COUNT_W-1:0];
        REG_GLIDE_SHIFT: cfg_nxt.glide_shift = cfg_data[SHIFT_W-1:0];
        REG_BASE_COUNT:  cfg_nxt.base_count  = cfg_data[COUNT_W-1:0];
        REG_BASE_SHIFT:  cfg_nxt.base_shift  = cfg_data[SHIFT_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cv_count    <= RST_COUNT;
      cfg_r.cv_shift    <= RST_SHIFT;
      cfg_r.cv_deadband <= RST_DEADBAND;
      cfg_r.glide_count <= RST_COUNT;
      cfg_r.glide_shift <= RST_SHIFT;
      cfg_r.base_count  <= RST_COUNT;
      cfg_r.base_shift  <= RST_SHIFT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // input register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!s1_valid_r || adv) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_sample_r <= in_adc_sample;
      s1_query_r  <= in_query_channel;
    end
  end

  // scan, average and store
  asad_channel_avg #(
    .MAX_AVERAGE_COUNT (MAX_AVERAGE_COUNT),
    .SAMPLE_BITS       (SAMPLE_BITS),
    .DISCARD_COUNT     (DISCARD_COUNT)
  ) u_avg (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .sample (s1_sample_r),
    .query  (s1_query_r),
    .cfg    (cfg_r),
    .res    (res)
  );

  // result register
  assign out_valid_nxt = adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_update_valid   = out_res_r.update_valid;
  assign out_update_channel = out_res_r.update_channel;
  assign out_update_value   = out_res_r.update_value;
  assign out_scan_channel   = out_res_r.scan_channel;
  assign out_query_value    = out_res_r.query_value;

  // an item in the input register is never dropped while the output waits
  `ASAD_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_r && !adv, s1_valid_r)
  // a reported average always moves the scan to the next channel
  `ASAD_ASSERT(a_report_adv, clk, rst_n, !(out_valid_r && out_res_r.update_valid) || (out_res_r.scan_channel == CHAN_W'(out_res_r.update_channel + 1'b1)))
  // no report leaves channel and value at zero
  `ASAD_ASSERT(a_no_report_zero, clk, rst_n, !(out_valid_r && !out_res_r.update_valid) || (out_res_r.update_channel == CH_CV_A && out_res_r.update_value == '0))

endmodule

@@ hdl/asad_channel_avg.sv @@
// ---------------------------------------------------------------------------
// asad_channel_avg
// Scan state, running sum, deadband compare and stored channel values.
// Produces the result of one sample and updates the state when step is high.
// ---------------------------------------------------------------------------
module asad_channel_avg
  import asad_pkg::*;
#(
  parameter int MAX_AVERAGE_COUNT = 64,
  parameter int SAMPLE_BITS       = 10,
  parameter int DISCARD_COUNT     = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [CHAN_W-1:0]   query,
  input  asad_cfg_t           cfg,
  output asad_res_t           res
);

  localparam logic [VALUE_W-1:0] SampleMask = VALUE_W'((32'd1 << SAMPLE_BITS) - 1);
  localparam logic [8:0]         MaxCnt     = 9'(MAX_AVERAGE_COUNT);
  localparam logic [DISC_W-1:0]  DiscRst    = DISC_W'(DISCARD_COUNT);

  logic [CHAN_W-1:0]  chan_r, chan_nxt;
  logic [DISC_W-1:0]  disc_r, disc_nxt;
  logic [COUNT_W-1:0] taken_r, taken_nxt;
  logic [VALUE_W-1:0] sum_r, sum_nxt;
  logic [VALUE_W-1:0] cva_r, cva_nxt;
  logic [VALUE_W-1:0] glide_r, glide_nxt;
  logic [VALUE_W-1:0] cvb_r, cvb_nxt;
  logic [VALUE_W-1:0] base_r, base_nxt;

  logic [VALUE_W-1:0] sample_ext;
  logic [VALUE_W-1:0] sum_inc;
  logic [COUNT_W-1:0] taken_inc;
  logic [COUNT_W-1:0] cnt_sel;
  logic [SHIFT_W-1:0] shift_sel;
  logic [8:0]         cnt_eff;
  logic               discarding;
  logic               done;
  logic [VALUE_W-1:0] avg;
  logic [VALUE_W-1:0] old_val;
  logic [VALUE_W-1:0] diff;
  logic               is_cv;
  logic               report;

  // per-kind count and shift
  always_comb begin
    unique case (chan_r)
      CH_GLIDE: begin
        cnt_sel   = cfg.glide_count;
        shift_sel = cfg.glide_shift;
      end
      CH_BASE: begin
        cnt_sel   = cfg.base_count;
        shift_sel = cfg.base_shift;
      end
      default: begin
        cnt_sel   = cfg.cv_count;
        shift_sel = cfg.cv_shift;
      end
    endcase
  end

  // zero count acts as one, large counts saturate
  always_comb begin
    cnt_eff = {2'b00, cnt_sel};
    if (cnt_sel == '0) begin
      cnt_eff = 9'd1;
    end else if (cnt_eff > MaxCnt) begin
      cnt_eff = MaxCnt;
    end
  end

  // accumulate and average
  assign sample_ext = {{(VALUE_W-SAMPLE_W){1'b0}}, sample} & SampleMask;
  assign sum_inc    = sum_r + sample_ext;
  assign taken_inc  = taken_r + 1'b1;
  assign discarding = (disc_r != '0);
  assign done       = !discarding && ({2'b00, taken_inc} >= cnt_eff);
  assign avg        = sum_inc >> shift_sel;

  // deadband compare against the stored cv value
  assign is_cv   = (chan_r == CH_CV_A) || (chan_r == CH_CV_B);
  assign old_val = (chan_r == CH_CV_B) ? cvb_r : cva_r;
  assign diff    = (old_val > avg) ? (old_val - avg) : (avg - old_val);
  assign report  = done && (!is_cv || (diff > cfg.cv_deadband));

  // next scan state and stored values
  always_comb begin
    chan_nxt  = chan_r;
    disc_nxt  = disc_r;
    taken_nxt = taken_r;
    sum_nxt   = sum_r;
    cva_nxt   = cva_r;
    glide_nxt = glide_r;
    cvb_nxt   = cvb_r;
    base_nxt  = base_r;
    if (discarding) begin
      disc_nxt = disc_r - 1'b1;
    end else if (done) begin
      sum_nxt   = '0;
      taken_nxt = '0;
      chan_nxt  = chan_r + 1'b1;
      disc_nxt  = DiscRst;
    end else begin
      sum_nxt   = sum_inc;
      taken_nxt = taken_inc;
    end
    if (report) begin
      unique case (chan_r)
        CH_CV_A:  cva_nxt   = avg;
        CH_GLIDE: glide_nxt = avg;
        CH_CV_B:  cvb_nxt   = avg;
        CH_BASE:  base_nxt  = avg;
        default:  cva_nxt   = cva_r;
      endcase
    end
  end

  // result of this sample
  always_comb begin
    res.update_valid   = report;
    res.update_channel = report ? chan_r : CH_CV_A;
    res.update_value   = report ? avg : '0;
    res.scan_channel   = chan_nxt;
    unique case (query)
      CH_CV_A:  res.query_value = cva_nxt;
      CH_GLIDE: res.query_value = glide_nxt;
      CH_CV_B:  res.query_value = cvb_nxt;
      CH_BASE:  res.query_value = base_nxt;
      default:  res.query_value = cva_nxt;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r  <= CH_CV_A;
      disc_r  <= DiscRst;
      taken_r <= '0;
      sum_r   <= '0;
      cva_r   <= '0;
      glide_r <= '0;
      cvb_r   <= '0;
      base_r  <= '0;
    end else if (step) begin
      chan_r  <= chan_nxt;
      disc_r  <= disc_nxt;
      taken_r <= taken_nxt;
      sum_r   <= sum_nxt;
      cva_r   <= cva_nxt;
      glide_r <= glide_nxt;
      cvb_r   <= cvb_nxt;
      base_r  <= base_nxt;
    end
  end

endmodule

@@ tb/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-channel converter scan with oversampling
// average and cv deadband. Samples go in through the valid/stall input
// channel, a transaction-level predictor works out every result, and the
// result channel is compared field by field against the oldest expectation.
// A short table of hand-picked samples runs first, then random samples over
// several register settings, with random gaps on both sides and one long stall.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import asad_pkg::*;

  localparam int MAX_AVG_SAMPLES   = 64;
  localparam int DROP_AFTER_SWITCH = 2;
  localparam int HOLD_CYCLES       = 300;
  localparam int LIMIT_CYCLES      = 200000;
  localparam int NUM_PHASES        = 8;
  localparam int PHASE_SAMPLES [NUM_PHASES] = '{130, 130, 60, 60, 60, 60, 60, 60};

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [SAMPLE_W-1:0] smp;
    logic [CHAN_W-1:0]   qch;
    bit                  typed;
    asad_res_t           res;
  } dir_row_t;

  // directed samples, run with cv count 1 / shift 0 / deadband 0,
  // glide count 0 / shift 7, base count 2 / shift 1
  localparam dir_row_t DIRECTED_ROWS [22] = '{
    '{10'd1023, CH_CV_A,  1'b1, '{1'b0, CH_CV_A,  16'd0,    CH_CV_A,  16'd0}},
    '{10'd0,    CH_BASE,  1'b1, '{1'b0, CH_CV_A,  16'd0,    CH_CV_A,  16'd0}},
    '{10'd1023, CH_CV_A,  1'b1, '{1'b1, CH_CV_A,  16'd1023, CH_GLIDE, 16'd1023}},
    '{10'd5,    CH_GLIDE, 1'b1, '{1'b0, CH_CV_A,  16'd0,    CH_GLIDE, 16'd0}},
    '{10'd0,    CH_CV_B,  1'b1, '{1'b0, CH_CV_A,  16'd0,    CH_GLIDE, 16'd0}},
    '{10'd1023, CH_GLIDE, 1'b1, '{1'b1, CH_GLIDE, 16'd7,    CH_CV_B,  16'd7}},
    '{10'd512,  CH_CV_A,  1'b1, '{1'b0, CH_CV_A,  16'd0,    CH_CV_B,  16'd1023}},
    '{10'd1,    CH_GLIDE, 1'b0, '0},
    '{10'd0,    CH_CV_B,  1'b1, '{1'b0, CH_CV_A,  16'd0,    CH_BASE,  16'd0}},
    '{10'd700,  CH_BASE,  1'b0, '0},
    '{10'd3,    CH_CV_A,  1'b0, '0},
    '{10'd1023, CH_BASE,  1'b0, '0},
    '{10'd1,    CH_BASE,  1'b1, '{1'b1, CH_BASE,  16'd512,  CH_CV_A,  16'd512}},
    '{10'd100,  CH_GLIDE, 1'b0, '0},
    '{10'd200,  CH_CV_B,  1'b0, '0},
    '{10'd1023, CH_CV_A,  1'b0, '0},
    '{10'd0,    CH_GLIDE, 1'b0, '0},
    '{10'd1023, CH_CV_B,  1'b0, '0},
    '{10'd0,    CH_GLIDE, 1'b0, '0},
    '{10'd682,  CH_BASE,  1'b0, '0},
    '{10'd341,  CH_CV_A,  1'b0, '0},
    '{10'd1,    CH_CV_B,  1'b1, '{1'b1, CH_CV_B,  16'd1,    CH_BASE,  16'd1}}
  };

  // block ports
  logic                 clk;
  logic                 rst_n            = 1'b0;
  logic                 in_valid         = 1'b0;
  logic                 in_stall;
  logic [SAMPLE_W-1:0]  in_adc_sample    = '0;
  logic [CHAN_W-1:0]    in_query_channel = '0;
  logic                 out_valid;
  logic                 out_stall        = 1'b0;
  logic                 out_update_valid;
  logic [CHAN_W-1:0]    out_update_channel;
  logic [VALUE_W-1:0]   out_update_value;
  logic [CHAN_W-1:0]    out_scan_channel;
  logic [VALUE_W-1:0]   out_query_value;
  logic                 cfg_valid        = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index        = '0;
  logic [VALUE_W-1:0]   cfg_data         = '0;

  // predictor state, mirrors the block after reset
  asad_cfg_t          cfg_shadow = '{RST_COUNT, RST_SHIFT, RST_DEADBAND, RST_COUNT, RST_SHIFT,
                                     RST_COUNT, RST_SHIFT};
  logic [CHAN_W-1:0]  scan_ch    = CH_CV_A;
  int                 drop_left  = DROP_AFTER_SWITCH;
  int                 n_taken    = 0;
  logic [VALUE_W-1:0] acc_sum    = '0;
  logic [VALUE_W-1:0] held_val [4] = '{default: '0};

  asad_res_t scan_result_q [$];
  asad_res_t oldest;

  int  errors     = 0;
  int  n_samples  = 0;
  int  n_checked  = 0;
  int  n_reports  = 0;
  int  n_settings = 0;
  int  cycle_cnt  = 0;
  bit  calm       = 1'b0;
  bit  hold_req   = 1'b0;

  adc_scan_average_deadband_top #(
    .MAX_AVERAGE_COUNT(MAX_AVG_SAMPLES),
    .SAMPLE_BITS      (SAMPLE_W),
    .DISCARD_COUNT    (DROP_AFTER_SWITCH)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_adc_sample     (in_adc_sample),
    .in_query_channel  (in_query_channel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_update_valid  (out_update_valid),
    .out_update_channel(out_update_channel),
    .out_update_value  (out_update_value),
    .out_scan_channel  (out_scan_channel),
    .out_query_value   (out_query_value),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("%0t ns: timeout, %0d results still outstanding", $time, scan_result_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // one accepted sample: drop, accumulate, and on the last sample of a
  // round average, apply the deadband, store and move to the next channel
  function automatic asad_res_t scan_average_step(input logic [SAMPLE_W-1:0] smp,
                                                  input logic [CHAN_W-1:0] qch);
    asad_res_t          res;
    int unsigned        need;
    logic [SHIFT_W-1:0] sh;
    logic [VALUE_W-1:0] avg;
    logic [VALUE_W-1:0] gap;
    bit                 report;
    res = '0;
    if (drop_left != 0) begin
      drop_left--;
    end else begin
      acc_sum = acc_sum + VALUE_W'(smp);
      n_taken++;
      case (scan_ch)
        CH_GLIDE: begin
          need = cfg_shadow.glide_count;
          sh   = cfg_shadow.glide_shift;
        end
        CH_BASE: begin
          need = cfg_shadow.base_count;
          sh   = cfg_shadow.base_shift;
        end
        default: begin
          need = cfg_shadow.cv_count;
          sh   = cfg_shadow.cv_shift;
        end
      endcase
      // zero acts as one, large counts clamp
      if (need == 0) need = 1;
      if (need > MAX_AVG_SAMPLES) need = MAX_AVG_SAMPLES;
      if (n_taken >= need) begin
        avg    = acc_sum >> sh;
        report = 1'b1;
        if (scan_ch == CH_CV_A || scan_ch == CH_CV_B) begin
          gap = (held_val[scan_ch] > avg) ? held_val[scan_ch] - avg : avg - held_val[scan_ch];
          if (gap > cfg_shadow.cv_deadband) held_val[scan_ch] = avg;
          else report = 1'b0;
        end else begin
          held_val[scan_ch] = avg;
        end
        if (report) begin
          res.update_valid   = 1'b1;
          res.update_channel = scan_ch;
          res.update_value   = avg;
        end
        acc_sum   = '0;
        n_taken   = 0;
        scan_ch   = scan_ch + 1'b1;
        drop_left = DROP_AFTER_SWITCH;
      end
    end
    res.scan_channel = scan_ch;
    res.query_value  = held_val[qch];
    return res;
  endfunction

  // register write, caller lowers cfg_valid after the last one
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_CV_COUNT:    cfg_shadow.cv_count    = data[COUNT_W-1:0];
      REG_CV_SHIFT:    cfg_shadow.cv_shift    = data[SHIFT_W-1:0];
      REG_CV_DEADBAND: cfg_shadow.cv_deadband = data;
      REG_GLIDE_COUNT: cfg_shadow.glide_count = data[COUNT_W-1:0];
      REG_GLIDE_SHIFT: cfg_shadow.glide_shift = data[SHIFT_W-1:0];
      REG_BASE_COUNT:  cfg_shadow.base_count  = data[COUNT_W-1:0];
      REG_BASE_SHIFT:  cfg_shadow.base_shift  = data[SHIFT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // drain the block, then write every register; junk fills unused data bits
  task automatic apply_config(input int cv_cnt, input int cv_sh, input int db,
                              input int g_cnt, input int g_sh, input int b_cnt,
                              input int b_sh, input bit junk);
    logic [VALUE_W-1:0] fill;
    in_valid <= 1'b0;
    while (scan_result_q.size() != 0) @(negedge clk);
    fill = junk ? VALUE_W'($urandom) : '0;
    reg_write(REG_CV_COUNT,    (fill & ~16'h7f) | VALUE_W'(cv_cnt));
    reg_write(REG_CV_SHIFT,    (fill & ~16'h07) | VALUE_W'(cv_sh));
    reg_write(REG_CV_DEADBAND, VALUE_W'(db));
    reg_write(REG_GLIDE_COUNT, (fill & ~16'h7f) | VALUE_W'(g_cnt));
    reg_write(REG_GLIDE_SHIFT, (fill & ~16'h07) | VALUE_W'(g_sh));
    reg_write(REG_BASE_COUNT,  (fill & ~16'h7f) | VALUE_W'(b_cnt));
    reg_write(REG_BASE_SHIFT,  (fill & ~16'h07) | VALUE_W'(b_sh));
    reg_write(REG_UNUSED,      VALUE_W'($urandom));
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // offer one sample, with an optional gap first; returns at the next falling edge
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic [CHAN_W-1:0] qch,
                             input bit typed, input asad_res_t typed_res);
    asad_res_t pred;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_adc_sample    <= smp;
    in_query_channel <= qch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = scan_average_step(smp, qch);
    scan_result_q.push_back(typed ? typed_res : pred);
    n_samples++;
    @(negedge clk);
  endtask

  function automatic int pick_count();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(65, 127);
      1:       return MAX_AVG_SAMPLES;
      default: return $urandom_range(0, 6);
    endcase
  endfunction

  task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                             input logic [VALUE_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (scan_result_q.size() == 0) begin
        errors++;
        $display("%0t ns: result expected none, got update %0d ch %0d value %0d",
                 $time, out_update_valid, out_update_channel, out_update_value);
      end else begin
        oldest = scan_result_q.pop_front();
        check_field("update_valid",   VALUE_W'(oldest.update_valid),   VALUE_W'(out_update_valid));
        check_field("update_channel", VALUE_W'(oldest.update_channel),
                    VALUE_W'(out_update_channel));
        check_field("update_value",   oldest.update_value,             out_update_value);
        check_field("scan_channel",   VALUE_W'(oldest.scan_channel),   VALUE_W'(out_scan_channel));
        check_field("query_value",    oldest.query_value,              out_query_value);
        n_checked++;
        if (out_update_valid) n_reports++;
      end
    end
  end

  // receiver stalls: random bursts, one long hold-off on request, none when calm
  initial begin : result_backpressure
    int n;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        n = HOLD_CYCLES;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 13);
      end else begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 16);
      end
      repeat (n) @(negedge clk);
    end
  end

  // stimulus
  initial begin : stimulus
    logic [SAMPLE_W-1:0] lvl [4];
    logic [SAMPLE_W-1:0] smp;
    int                  db;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    apply_config(1, 0, 0, 0, 7, 2, 1, 1'b0);
    foreach (DIRECTED_ROWS[i])
      send_sample(DIRECTED_ROWS[i].smp, DIRECTED_ROWS[i].qch, DIRECTED_ROWS[i].typed,
                  DIRECTED_ROWS[i].res);

    // random phases over several register settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0:       db = 0;
        1:       db = $urandom_range(1, 8);
        2:       db = $urandom_range(0, 65535);
        default: db = 65535;
      endcase
      case (ph)
        0: apply_config(RST_COUNT, RST_SHIFT, RST_DEADBAND, RST_COUNT, RST_SHIFT,
                        RST_COUNT, RST_SHIFT, 1'b0);
        1: apply_config(127, 6, 65535, 127, 7, MAX_AVG_SAMPLES, 0, 1'b0);
        2: apply_config(0, 0, 0, 0, 0, 0, 0, 1'b1);
        default: apply_config(pick_count(), $urandom_range(0, 7), db, pick_count(),
                              $urandom_range(0, 7), pick_count(), $urandom_range(0, 7), 1'b1);
      endcase
      if (ph == 0) hold_req = 1'b1;
      if (ph == NUM_PHASES - 1) calm = 1'b1;
      // each channel hovers near a level so the deadband matters
      foreach (lvl[c]) lvl[c] = SAMPLE_W'($urandom_range(0, 1020));
      for (int k = 0; k < PHASE_SAMPLES[ph]; k++) begin
        if ($urandom_range(0, 1) == 0) smp = SAMPLE_W'($urandom);
        else smp = lvl[scan_ch] + SAMPLE_W'($urandom_range(0, 3));
        send_sample(smp, CHAN_W'($urandom), 1'b0, '0);
      end
    end

    // drain and let the pipeline settle
    in_valid <= 1'b0;
    while (scan_result_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("run covered %0d samples over %0d register settings", n_samples, n_settings);
    $display("%0d results checked, %0d of them reported averages", n_checked, n_reports);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
